// ===== rtl/gdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gdfs_pkg: shared types and constants
// Sizes, status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package gdfs_pkg;

   localparam int MaxVertices = 64;
   localparam int MaxArcs     = 1024;
   localparam int VtxW        = 6;
   localparam int ArcW        = 11;   // holds MaxArcs as the end-of-list marker
   localparam int AdrW        = 10;
   localparam int CntW        = 7;

   localparam logic [ArcW-1:0] NoArc = ArcW'(MaxArcs);

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_PRESENT = 3'd1,
      ST_FULL    = 3'd2,
      ST_RANGE   = 3'd3,
      ST_RECORD  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_INS_HEAD,
      S_INS_WALK,
      S_INS_WAIT,
      S_INS_DONE,
      S_ROOT,
      S_ROOT_LD,
      S_TOP,
      S_ARC_WAIT,
      S_ARC,
      S_EMIT_RD,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic ins_init;     // latch request, read list head of source
      logic ins_head;     // load walk pointer from list head read
      logic ins_step;     // issue read of arc at walk pointer
      logic ins_adv;      // follow link after read data is back
      logic ins_add;      // append arc
      logic ins_resp;     // emit insert result
      logic clr;          // clear seen flag at scan index, advance scan
      logic scan_rst;     // reset scan index
      logic root_try;     // examine scan vertex as root, read its list head
      logic cur_load;     // load top cursor from list head read
      logic top_rd;       // read arc at cursor of top frame
      logic head_tgt;     // read list head of arc target
      logic arc_do;       // act on arc read data
      logic pop;          // finish top frame
      logic emit_rd;      // read result arrays at scan index
      logic emit;         // emit record
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic walk_end;     // walk pointer is end-of-list
      logic hit;          // arc read data target matches
      logic present;      // walk found the arc
      logic full;
      logic scan_end;     // scan index reached vertex count
      logic scan_seen;
      logic stack_empty;
      logic top_end;      // top frame cursor is end-of-list
      logic scan_last;
   } sts_type;

endpackage

// ===== rtl/gdfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdfs_ctrl: sequencing controller
// Steps the insert list walk and the depth-first search over the datapath.
// ----------------------------------------------------------------------------
module gdfs_ctrl
   import gdfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    req_op,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = req_op ? S_CLEAR : S_INS_HEAD;
            end
         end
         S_INS_HEAD: state_in = S_INS_WALK;
         S_INS_WALK: begin
            if (!sts.in_range || sts.walk_end) begin
               state_in = S_INS_DONE;
            end else begin
               state_in = S_INS_WAIT;
            end
         end
         S_INS_WAIT: state_in = sts.hit ? S_INS_DONE : S_INS_WALK;
         S_INS_DONE: state_in = S_IDLE;
         S_CLEAR: begin
            if (sts.scan_end) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (sts.scan_end) begin
               state_in = S_EMIT_RD;
            end else if (!sts.scan_seen) begin
               state_in = S_ROOT_LD;
            end
         end
         S_ROOT_LD: state_in = S_TOP;
         S_TOP: begin
            if (sts.stack_empty) begin
               state_in = S_ROOT;
            end else if (!sts.top_end) begin
               state_in = S_ARC_WAIT;
            end
         end
         S_ARC_WAIT: state_in = S_ARC;
         S_ARC:      state_in = S_TOP;
         S_EMIT_RD:  state_in = S_EMIT;
         S_EMIT:     state_in = sts.scan_last ? S_IDLE : S_EMIT_RD;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.ins_init = start;
            cmd.scan_rst = start;
         end
         S_INS_HEAD: cmd.ins_head = 1'b1;
         S_INS_WALK: cmd.ins_step = sts.in_range && !sts.walk_end;
         S_INS_WAIT: cmd.ins_adv = 1'b1;
         S_INS_DONE: begin
            cmd.ins_resp = 1'b1;
            cmd.ins_add  = sts.in_range && !sts.present && !sts.full;
         end
         S_CLEAR: begin
            cmd.clr      = !sts.scan_end;
            cmd.scan_rst = sts.scan_end;
         end
         S_ROOT: begin
            cmd.root_try = !sts.scan_end;
            cmd.scan_rst = sts.scan_end;
         end
         S_ROOT_LD: cmd.cur_load = 1'b1;
         S_TOP: begin
            cmd.top_rd = !sts.stack_empty && !sts.top_end;
            cmd.pop    = !sts.stack_empty && sts.top_end;
         end
         S_ARC_WAIT: cmd.head_tgt = 1'b1;
         S_ARC:      cmd.arc_do   = 1'b1;
         S_EMIT_RD:  cmd.emit_rd  = 1'b1;
         S_EMIT:     cmd.emit     = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== rtl/gdfs_datapath.sv =====
// ----------------------------------------------------------------------------
// gdfs_datapath: graph store and search datapath
// Arc memories, list heads, walk stack, numbering arrays and result register.
// ----------------------------------------------------------------------------
module gdfs_datapath
   import gdfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [VtxW-1:0]   req_from_vertex,
   input  logic [VtxW-1:0]   req_to_vertex,
   input  logic              csr_write,
   input  logic [CntW-1:0]   csr_data,
   output sts_type           sts,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [VtxW-1:0]   rsp_vertex_id,
   output logic [VtxW-1:0]   rsp_pre_number,
   output logic [VtxW-1:0]   rsp_post_number,
   output logic [VtxW-1:0]   rsp_parent_vertex,
   output logic              rsp_last
);

   // memories
   logic [VtxW-1:0] arc_target_mem [MaxArcs];
   logic [ArcW-1:0] arc_link_mem   [MaxArcs];
   logic [ArcW-1:0] head_mem       [MaxVertices];
   logic [VtxW-1:0] pre_mem        [MaxVertices];
   logic [VtxW-1:0] post_mem       [MaxVertices];
   logic [VtxW-1:0] parent_mem     [MaxVertices];
   logic [VtxW-1:0] stk_vtx_mem    [MaxVertices];
   logic [ArcW-1:0] stk_cur_mem    [MaxVertices];

   // a list head without its valid bit reads as end-of-list
   logic [MaxVertices-1:0] head_vld_ff;
   logic [MaxVertices-1:0] seen_ff;

   logic [CntW-1:0] vcount_ff;
   logic [ArcW-1:0] total_ff;
   logic [VtxW-1:0] from_ff, to_ff;
   logic [ArcW-1:0] walk_ff;
   logic            hit_ff;
   logic [CntW-1:0] scan_ff;
   logic [CntW-1:0] depth_ff;
   logic [VtxW-1:0] top_vtx_ff;
   logic [ArcW-1:0] top_cur_ff;
   logic [VtxW:0]   pre_cnt_ff, post_cnt_ff;
   logic [VtxW-1:0] rd_tgt_ff;
   logic [ArcW-1:0] rd_link_ff;
   logic [VtxW-1:0] rd_pre_ff, rd_post_ff, rd_par_ff;
   logic [ArcW-1:0] head_rd_ff;
   logic            head_rd_vld_ff;

   logic [CntW-1:0] nv;
   logic [VtxW-1:0] scan_idx, top_idx, depth_idx;
   logic [VtxW-1:0] head_addr;
   logic            head_rd_en;
   logic [ArcW-1:0] head_val;
   logic            tgt_ok;

   always_comb begin
      priority if (vcount_ff == '0) begin
         nv = CntW'(1);
      end else if (vcount_ff > CntW'(MaxVertices)) begin
         nv = CntW'(MaxVertices);
      end else begin
         nv = vcount_ff;
      end
   end

   assign scan_idx   = scan_ff[VtxW-1:0];
   assign top_idx    = VtxW'(depth_ff - CntW'(1));
   assign depth_idx  = depth_ff[VtxW-1:0];
   assign head_addr  = cmd.ins_init ? req_from_vertex :
                       (cmd.head_tgt ? rd_tgt_ff : scan_idx);
   assign head_rd_en = cmd.ins_init || cmd.root_try || cmd.head_tgt;
   assign head_val   = head_rd_vld_ff ? head_rd_ff : NoArc;
   assign tgt_ok     = ({1'b0, rd_tgt_ff} < nv) && !seen_ff[rd_tgt_ff]
                       && (depth_ff < CntW'(MaxVertices));

   always_comb begin
      sts.in_range    = ({1'b0, from_ff} < nv) && ({1'b0, to_ff} < nv);
      sts.walk_end    = (walk_ff == NoArc);
      sts.hit         = (rd_tgt_ff == to_ff);
      sts.present     = hit_ff;
      sts.full        = (total_ff == NoArc);
      sts.scan_end    = (scan_ff == nv);
      sts.scan_seen   = seen_ff[scan_idx];
      sts.stack_empty = (depth_ff == '0);
      sts.top_end     = (top_cur_ff == NoArc);
      sts.scan_last   = (scan_ff == nv - CntW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CntW'(MaxVertices);
      end else if (csr_write) begin
         vcount_ff <= csr_data;
      end
   end

   // arc memories: one write, one read port
   always_ff @(posedge clock) begin
      if (cmd.ins_add) begin
         arc_target_mem[total_ff[AdrW-1:0]] <= to_ff;
         arc_link_mem[total_ff[AdrW-1:0]]   <= head_val;
      end
      if (cmd.ins_step) begin
         rd_tgt_ff  <= arc_target_mem[walk_ff[AdrW-1:0]];
         rd_link_ff <= arc_link_mem[walk_ff[AdrW-1:0]];
      end else if (cmd.top_rd) begin
         rd_tgt_ff  <= arc_target_mem[top_cur_ff[AdrW-1:0]];
         rd_link_ff <= arc_link_mem[top_cur_ff[AdrW-1:0]];
      end
   end

   // list head memory: one write, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.ins_add) begin
         head_mem[from_ff] <= total_ff;
      end
      if (head_rd_en) begin
         head_rd_ff <= head_mem[head_addr];
      end
   end

   // insert path, head valid bits and arc count
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= '0;
         head_vld_ff    <= '0;
         head_rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.ins_add) begin
            head_vld_ff[from_ff] <= 1'b1;
            total_ff             <= total_ff + ArcW'(1);
         end
         if (head_rd_en) begin
            head_rd_vld_ff <= head_vld_ff[head_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_init) begin
         from_ff <= req_from_vertex;
         to_ff   <= req_to_vertex;
         hit_ff  <= 1'b0;
      end else if (cmd.ins_head) begin
         walk_ff <= head_val;
      end else if (cmd.ins_adv) begin
         walk_ff <= rd_link_ff;
         hit_ff  <= sts.hit;
      end
   end

   // search state
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         depth_ff    <= '0;
         seen_ff     <= '0;
         pre_cnt_ff  <= '0;
         post_cnt_ff <= '0;
      end else begin
         if (cmd.scan_rst) begin
            scan_ff <= '0;
         end
         if (cmd.clr) begin
            seen_ff[scan_idx] <= 1'b0;
            scan_ff           <= scan_ff + CntW'(1);
            pre_cnt_ff        <= '0;
            post_cnt_ff       <= '0;
         end
         if (cmd.root_try) begin
            scan_ff <= scan_ff + CntW'(1);
            if (!seen_ff[scan_idx]) begin
               seen_ff[scan_idx]   <= 1'b1;
               depth_ff            <= CntW'(1);
               top_vtx_ff          <= scan_idx;
               pre_cnt_ff          <= pre_cnt_ff + (VtxW+1)'(1);
            end
         end
         if (cmd.arc_do) begin
            if (tgt_ok) begin
               seen_ff[rd_tgt_ff]   <= 1'b1;
               depth_ff             <= depth_ff + CntW'(1);
               top_vtx_ff           <= rd_tgt_ff;
               pre_cnt_ff           <= pre_cnt_ff + (VtxW+1)'(1);
            end
         end
         if (cmd.pop) begin
            depth_ff    <= depth_ff - CntW'(1);
            post_cnt_ff <= post_cnt_ff + (VtxW+1)'(1);
            if (depth_ff > CntW'(1)) begin
               top_vtx_ff <= stk_vtx_mem[VtxW'(depth_ff - CntW'(2))];
            end
         end
         if (cmd.emit) begin
            scan_ff <= scan_ff + CntW'(1);
         end
      end
   end

   // numbering arrays, stack columns and top frame cursor
   always_ff @(posedge clock) begin
      if (cmd.root_try && !seen_ff[scan_idx]) begin
         pre_mem[scan_idx]    <= pre_cnt_ff[VtxW-1:0];
         parent_mem[scan_idx] <= scan_idx;
         stk_vtx_mem[0]       <= scan_idx;
      end
      if (cmd.cur_load) begin
         top_cur_ff <= head_val;
      end
      if (cmd.arc_do) begin
         if (tgt_ok) begin
            pre_mem[rd_tgt_ff]     <= pre_cnt_ff[VtxW-1:0];
            parent_mem[rd_tgt_ff]  <= top_vtx_ff;
            stk_vtx_mem[depth_idx] <= rd_tgt_ff;
            // park the advanced cursor of the frame below the new top
            stk_cur_mem[top_idx]   <= rd_link_ff;
            top_cur_ff             <= head_val;
         end else begin
            top_cur_ff <= rd_link_ff;
         end
      end
      if (cmd.pop) begin
         post_mem[top_vtx_ff] <= post_cnt_ff[VtxW-1:0];
         if (depth_ff > CntW'(1)) begin
            top_cur_ff <= stk_cur_mem[VtxW'(depth_ff - CntW'(2))];
         end
      end
      if (cmd.emit_rd) begin
         rd_pre_ff  <= pre_mem[scan_idx];
         rd_post_ff <= post_mem[scan_idx];
         rd_par_ff  <= parent_mem[scan_idx];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.ins_resp || cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_resp) begin
         priority if (!sts.in_range) begin
            rsp_status <= ST_RANGE;
         end else if (hit_ff) begin
            rsp_status <= ST_PRESENT;
         end else if (sts.full) begin
            rsp_status <= ST_FULL;
         end else begin
            rsp_status <= ST_ADDED;
         end
         rsp_vertex_id     <= '0;
         rsp_pre_number    <= '0;
         rsp_post_number   <= '0;
         rsp_parent_vertex <= '0;
         rsp_last          <= 1'b1;
      end else if (cmd.emit) begin
         rsp_status        <= ST_RECORD;
         rsp_vertex_id     <= scan_idx;
         rsp_pre_number    <= rd_pre_ff;
         rsp_post_number   <= rd_post_ff;
         rsp_parent_vertex <= rd_par_ff;
         rsp_last          <= sts.scan_last;
      end
   end

endmodule

// ===== rtl/graph_dfs_pre_post_numbering_unit.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_pre_post_numbering_unit: depth-first search numbering block
//
//   channel  ports               handshake
//   request  req_*               start high while busy low
//   result   rsp_*               rsp_valid strobe, one cycle
//   config   csr_write, csr_data write when csr_write high
//
// An insert walks the arcs on the source list (one arc memory read port, one
// list head read). A search clears every seen flag, checks each vertex as a
// root, walks the arcs of each root's tree and finishes each vertex, then
// emits one record per vertex.
// Synchronous reset empties all lists and the arc count. No back-pressure.
// ----------------------------------------------------------------------------
module graph_dfs_pre_post_numbering_unit
   import gdfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic            req_op,
   input  logic [5:0]      req_from_vertex,
   input  logic [5:0]      req_to_vertex,
   input  logic            csr_write,
   input  logic [6:0]      csr_data,
   output logic            rsp_valid,
   output logic [2:0]      rsp_status,
   output logic [5:0]      rsp_vertex_id,
   output logic [5:0]      rsp_pre_number,
   output logic [5:0]      rsp_post_number,
   output logic [5:0]      rsp_parent_vertex,
   output logic            rsp_last
);

   cmd_type cmd;
   sts_type sts;

   gdfs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .sts    (sts),
      .busy   (busy),
      .cmd    (cmd)
   );

   gdfs_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_from_vertex   (req_from_vertex),
      .req_to_vertex     (req_to_vertex),
      .csr_write         (csr_write),
      .csr_data          (csr_data),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_vertex_id     (rsp_vertex_id),
      .rsp_pre_number    (rsp_pre_number),
      .rsp_post_number   (rsp_post_number),
      .rsp_parent_vertex (rsp_parent_vertex),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== bench/gdfs_checker.sv =====
// ----------------------------------------------------------------------------
// gdfs_checker: search numbering predictor and result checker
// Watches the request, result and register channels, keeps its own copy of
// the graph, predicts every result and compares each field in order.
// ----------------------------------------------------------------------------
module gdfs_checker
   import gdfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_op,
   input  logic [5:0] req_from_vertex,
   input  logic [5:0] req_to_vertex,
   input  logic       csr_write,
   input  logic [6:0] csr_data,
   input  logic       rsp_valid,
   input  logic [2:0] rsp_status,
   input  logic [5:0] rsp_vertex_id,
   input  logic [5:0] rsp_pre_number,
   input  logic [5:0] rsp_post_number,
   input  logic [5:0] rsp_parent_vertex,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      status_type status;
      logic [5:0] vertex_id;
      logic [5:0] pre_number;
      logic [5:0] post_number;
      logic [5:0] parent_vertex;
      logic       last;
   } record_type;

   record_type  expected_q[$];
   logic [6:0]  vertex_reg;
   int          head_of[MaxVertices];
   int          target_of[MaxArcs];
   int          link_of[MaxArcs];
   int          arcs_stored;
   int          pre_of[MaxVertices];
   int          post_of[MaxVertices];
   int          parent_of[MaxVertices];

   assign pending = expected_q.size();

   function automatic int active_vertices();
      if (vertex_reg < 1) return 1;
      if (vertex_reg > MaxVertices) return MaxVertices;
      return vertex_reg;
   endfunction

   function automatic status_type add_arc(int v, int w);
      int nv;
      int a;
      nv = active_vertices();
      if (v >= nv || w >= nv) return ST_RANGE;
      a = head_of[v];
      while (a < MaxArcs) begin
         if (target_of[a] == w) return ST_PRESENT;
         a = link_of[a];
      end
      if (arcs_stored >= MaxArcs) return ST_FULL;
      target_of[arcs_stored] = w;
      link_of[arcs_stored]   = head_of[v];
      head_of[v]             = arcs_stored;
      arcs_stored++;
      return ST_ADDED;
   endfunction

   function automatic void number_vertices(int nv);
      int  frame_vtx[MaxVertices];
      int  frame_cur[MaxVertices];
      bit  seen[MaxVertices];
      int  pre_n, post_n, depth, w, top;
      pre_n  = 0;
      post_n = 0;
      for (int i = 0; i < MaxVertices; i++) seen[i] = 0;
      for (int r = 0; r < nv; r++) begin
         if (!seen[r]) begin
            seen[r]      = 1;
            parent_of[r] = r;
            pre_of[r]    = pre_n++;
            frame_vtx[0] = r;
            frame_cur[0] = head_of[r];
            depth        = 1;
            while (depth > 0) begin
               top = depth - 1;
               if (frame_cur[top] >= MaxArcs) begin
                  post_of[frame_vtx[top]] = post_n++;
                  depth--;
               end else begin
                  w = target_of[frame_cur[top]];
                  frame_cur[top] = link_of[frame_cur[top]];
                  // stale arcs past the vertex count are skipped
                  if (w < nv && !seen[w] && depth < MaxVertices) begin
                     seen[w]          = 1;
                     parent_of[w]     = frame_vtx[top];
                     pre_of[w]        = pre_n++;
                     frame_vtx[depth] = w;
                     frame_cur[depth] = head_of[w];
                     depth++;
                  end
               end
            end
         end
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      record_type rec;
      record_type want;
      int nv;
      if (reset) begin
         vertex_reg  = 7'd64;
         arcs_stored = 0;
         fail_count  = 0;
         for (int i = 0; i < MaxVertices; i++) head_of[i] = MaxArcs;
         expected_q.delete();
      end else begin
         if (csr_write) vertex_reg = csr_data;
         if (start && !busy) begin
            if (req_op == 1'b0) begin
               rec = '0;
               rec.status = add_arc(req_from_vertex, req_to_vertex);
               rec.last   = 1'b1;
               expected_q.push_back(rec);
            end else begin
               nv = active_vertices();
               number_vertices(nv);
               for (int i = 0; i < nv; i++) begin
                  rec.status        = ST_RECORD;
                  rec.vertex_id     = 6'(i);
                  rec.pre_number    = 6'(pre_of[i]);
                  rec.post_number   = 6'(post_of[i]);
                  rec.parent_vertex = 6'(parent_of[i]);
                  rec.last          = (i == nv - 1);
                  expected_q.push_back(rec);
               end
            end
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result, status", rsp_status, -1);
            end else begin
               want = expected_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_vertex_id !== want.vertex_id)
                  report_mismatch("vertex_id", rsp_vertex_id, want.vertex_id);
               if (rsp_pre_number !== want.pre_number)
                  report_mismatch("pre_number", rsp_pre_number, want.pre_number);
               if (rsp_post_number !== want.post_number)
                  report_mismatch("post_number", rsp_post_number, want.post_number);
               if (rsp_parent_vertex !== want.parent_vertex)
                  report_mismatch("parent_vertex", rsp_parent_vertex, want.parent_vertex);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
      end
   end

endmodule

// ===== bench/tb_graph_dfs_pre_post_numbering_unit.sv =====
// ----------------------------------------------------------------------------
// tb_graph_dfs_pre_post_numbering_unit: search numbering block testbench
// Directed arc inserts and searches over corner vertex counts, random graph
// phases (all but one with bursty request gaps), then a short run with no
// gaps; results are checked by gdfs_checker.
// ----------------------------------------------------------------------------
module tb_graph_dfs_pre_post_numbering_unit;
   import gdfs_pkg::*;

   localparam logic OpInsert = 1'b0;
   localparam logic OpSearch = 1'b1;
   localparam int   CycleLimit = 3000000;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_op;
   logic [5:0] req_from_vertex;
   logic [5:0] req_to_vertex;
   logic       csr_write;
   logic [6:0] csr_data;
   logic       rsp_valid;
   logic [2:0] rsp_status;
   logic [5:0] rsp_vertex_id;
   logic [5:0] rsp_pre_number;
   logic [5:0] rsp_post_number;
   logic [5:0] rsp_parent_vertex;
   logic       rsp_last;
   int         fail_count;
   int         pending;
   int         cycle_count;
   bit         gaps_on;

   graph_dfs_pre_post_numbering_unit u_top (.*);

   gdfs_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_request(logic op, int from_v, int to_v);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      start           <= 1'b1;
      req_op          <= op;
      req_from_vertex <= 6'(from_v);
      req_to_vertex   <= 6'(to_v);
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_vertex_count(int value);
      drain();
      csr_write <= 1'b1;
      csr_data  <= 7'(value);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_phase(int count, int nv);
      int hi;
      for (int i = 0; i < count; i++) begin
         // mostly in-range arcs, some over the whole field
         hi = ($urandom_range(0, 4) == 0) ? 63 : nv - 1;
         if ($urandom_range(0, 7) == 0)
            send_request(OpSearch, $urandom_range(0, 63), $urandom_range(0, 63));
         else
            send_request(OpInsert, $urandom_range(0, hi), $urandom_range(0, hi));
      end
      send_request(OpSearch, 0, 0);
   endtask

   initial begin
      int nv;
      cycle_count     = 0;
      gaps_on         = 1;
      reset           = 1;
      start           = 0;
      req_op          = 0;
      req_from_vertex = 0;
      req_to_vertex   = 0;
      csr_write       = 0;
      csr_data        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small graph with duplicates, self loop and range errors
      set_vertex_count(8);
      send_request(OpInsert, 0, 1);
      send_request(OpInsert, 0, 2);
      send_request(OpInsert, 1, 3);
      send_request(OpInsert, 0, 1);
      send_request(OpInsert, 2, 3);
      send_request(OpInsert, 3, 0);
      send_request(OpInsert, 7, 7);
      send_request(OpInsert, 8, 0);
      send_request(OpInsert, 0, 9);
      send_request(OpInsert, 63, 63);
      send_request(OpSearch, 0, 0);
      // zero counts as one vertex
      set_vertex_count(0);
      send_request(OpInsert, 0, 0);
      send_request(OpInsert, 0, 1);
      send_request(OpSearch, 63, 63);
      // above the maximum saturates
      set_vertex_count(127);
      send_request(OpInsert, 63, 0);
      send_request(OpInsert, 0, 63);
      send_request(OpInsert, 62, 63);
      send_request(OpSearch, 0, 0);
      // lowered count leaves stale arcs behind
      set_vertex_count(3);
      send_request(OpSearch, 0, 0);

      for (int p = 0; p < 6; p++) begin
         gaps_on = (p != 2);
         case ($urandom_range(0, 3))
            0: nv = 2;
            1: nv = 64;
            default: nv = $urandom_range(1, 16);
         endcase
         set_vertex_count(nv);
         random_phase(38, nv);
      end

      // closing run, no gaps
      gaps_on = 0;
      set_vertex_count(64);
      for (int v = 0; v < 6; v++)
         send_request(OpInsert, v, v + 1);
      send_request(OpSearch, 0, 0);
      start <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
